[rtl/spjq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority job queue package
// Shared widths, operation and status codes, and the cell control struct.
// ----------------------------------------------------------------------------
package spjq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_NAME_BITS   = 64;

  localparam int NAME_W  = 64;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;

  // Input word: job_name, job_priority (80 bits, no padding needed).
  localparam int IN_DATA_W  = 80;
  // Output word: out_name, out_priority, job_count (85 bits, padded to 88).
  localparam int OUT_DATA_W = 88;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic add;
    logic remove;
  } spjq_ctrl_t;

endpackage

[rtl/spjq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority job queue cell
// Holds one job and moves it toward the tail on insert and toward the head
// on remove, deciding locally from its neighbor's position flag.
// ----------------------------------------------------------------------------
module spjq_cell #(
  parameter int NAME_BITS = spjq_pkg::DEFAULT_NAME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spjq_pkg::spjq_ctrl_t                ctrl_i,
  input  logic [NAME_BITS-1:0]                new_name_i,
  input  logic signed [spjq_pkg::PRIO_W-1:0]  new_prio_i,
  input  logic                                beats_last_i,
  input  logic                                left_behind_i,
  input  logic                                left_valid_i,
  input  logic [NAME_BITS-1:0]                left_name_i,
  input  logic signed [spjq_pkg::PRIO_W-1:0]  left_prio_i,
  input  logic                                right_valid_i,
  input  logic [NAME_BITS-1:0]                right_name_i,
  input  logic signed [spjq_pkg::PRIO_W-1:0]  right_prio_i,
  output logic                                behind_o,
  output logic                                valid_o,
  output logic [NAME_BITS-1:0]                name_o,
  output logic signed [spjq_pkg::PRIO_W-1:0]  prio_o,
  output logic                                lt_o,
  output logic                                hit_o
);
  import spjq_pkg::*;

  logic                     valid_q, valid_d;
  logic [NAME_BITS-1:0]     name_q, name_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic                     behind;

  // The new job lands behind this cell unless it would be placed ahead of it.
  // Valid cells where that holds form a prefix of the row.
  assign behind   = valid_q && !((prio_q <= new_prio_i) && beats_last_i);
  assign behind_o = behind;
  assign valid_o  = valid_q;
  assign name_o   = name_q;
  assign prio_o   = prio_q;
  assign lt_o     = valid_q && (prio_q < new_prio_i);
  assign hit_o    = valid_q && (name_q == new_name_i);

  always_comb begin
    valid_d = valid_q;
    name_d  = name_q;
    prio_d  = prio_q;
    if (ctrl_i.add) begin
      valid_d = valid_q | left_valid_i;
      if (!behind) begin
        if (left_behind_i) begin
          name_d = new_name_i;
          prio_d = new_prio_i;
        end else begin
          name_d = left_name_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.remove) begin
      valid_d = right_valid_i;
      name_d  = right_name_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_q <= name_d;
    prio_q <= prio_d;
  end

endmodule

[rtl/sorted_priority_job_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority job queue
// A row of cells keeps jobs in descending priority order; add, remove and
// search each produce one registered result word per op.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata fields (low bit up)             tuser
//  s_axis    in         job_name, job_priority                op
//  m_axis    out        out_name, out_priority, job_count     status
//
//  One word is taken per cycle and its result is registered the cycle after.
//  Throughput is set by the single result register: a new word is taken
//  whenever that register is empty or being drained in the same cycle.
//  Reset clears the valid flags of all cells, the job count and the result valid flag; no sweep.
//  A stall on m_axis holds the result and stops the input side.
// ----------------------------------------------------------------------------
module sorted_priority_job_queue #(
  parameter int QUEUE_DEPTH = spjq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int NAME_BITS   = spjq_pkg::DEFAULT_NAME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // job_name [63:0], job_priority [79:64]
  input  logic [spjq_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // op [1:0]
  input  logic [1:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_name [63:0], out_priority [79:64], job_count [84:80], zero [87:85]
  output logic [spjq_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                        m_axis_tuser_o
);
  import spjq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_e                      op;
  logic [NAME_BITS-1:0]     in_name;
  logic signed [PRIO_W-1:0] in_prio;
  logic                     accept;
  spjq_ctrl_t               ctrl;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     full, empty;

  logic                     behind_w [QUEUE_DEPTH+1];
  logic                     valid_w  [QUEUE_DEPTH+2];
  logic [NAME_BITS-1:0]     name_w   [QUEUE_DEPTH+2];
  logic signed [PRIO_W-1:0] prio_w   [QUEUE_DEPTH+2];
  logic [QUEUE_DEPTH-1:0]   lt_vec, hit_vec, first_hit;
  logic                     beats_last;

  logic signed [PRIO_W-1:0] hit_prio;
  status_e                  status_d;
  logic [NAME_W-1:0]        res_name_d;
  logic signed [PRIO_W-1:0] res_prio_d;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [NAME_W-1:0]        out_name_q;
  logic signed [PRIO_W-1:0] out_prio_q;
  logic [COUNT_W-1:0]       out_count_q;

  assign op      = op_e'(s_axis_tuser_i);
  assign in_name = s_axis_tdata_i[NAME_BITS-1:0];
  assign in_prio = s_axis_tdata_i[NAME_W +: PRIO_W];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_q == '0);

  assign ctrl.add    = accept && (op == OP_ADD) && !full;
  assign ctrl.remove = accept && (op == OP_REMOVE) && !empty;

  // Cell 0 sees the new job as its left neighbor; the last cell sees an
  // empty right neighbor. Slot 0 of the arrays is the head boundary.
  assign behind_w[0]             = 1'b1;
  assign valid_w[0]              = 1'b1;
  assign name_w[0]               = in_name;
  assign prio_w[0]               = in_prio;
  assign valid_w[QUEUE_DEPTH+1]  = 1'b0;
  assign name_w[QUEUE_DEPTH+1]   = in_name;
  assign prio_w[QUEUE_DEPTH+1]   = in_prio;

  // Since the row is sorted, the new job beats the tail exactly when some
  // stored job has a strictly lower priority.
  assign beats_last = |lt_vec;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spjq_cell #(
      .NAME_BITS(NAME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_name_i    (in_name),
      .new_prio_i    (in_prio),
      .beats_last_i  (beats_last),
      .left_behind_i (behind_w[i]),
      .left_valid_i  (valid_w[i]),
      .left_name_i   (name_w[i]),
      .left_prio_i   (prio_w[i]),
      .right_valid_i (valid_w[i+2]),
      .right_name_i  (name_w[i+2]),
      .right_prio_i  (prio_w[i+2]),
      .behind_o      (behind_w[i+1]),
      .valid_o       (valid_w[i+1]),
      .name_o        (name_w[i+1]),
      .prio_o        (prio_w[i+1]),
      .lt_o          (lt_vec[i]),
      .hit_o         (hit_vec[i])
    );
  end

  // Lowest set bit picks the match nearest the head.
  assign first_hit = hit_vec & (~hit_vec + QUEUE_DEPTH'(1));

  always_comb begin
    hit_prio = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_prio = hit_prio | (first_hit[i] ? prio_w[i+1] : '0);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.add) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctrl.remove) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  always_comb begin
    status_d   = ST_OK;
    res_name_d = '0;
    res_prio_d = '0;
    case (op)
      OP_ADD: begin
        if (full) begin
          status_d = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          res_name_d = NAME_W'(name_w[1]);
          res_prio_d = prio_w[1];
        end
      end
      OP_SEARCH: begin
        if (|hit_vec) begin
          res_name_d = NAME_W'(in_name);
          res_prio_d = hit_prio;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status_d;
      out_name_q   <= res_name_d;
      out_prio_q   <= res_prio_d;
      out_count_q  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, out_prio_q, out_name_q};

endmodule

[test/sorted_priority_job_queue_tb.sv]
// ----------------------------------------------------------------------------
// Sorted priority job queue testbench
// Drives add, remove, search and no-op words into the queue with bursty input
// and a stalling output side. A behavioral copy of the queue in the bench
// predicts every result word, and a monitor compares the words in order.
// ----------------------------------------------------------------------------
module sorted_priority_job_queue_tb;
  import spjq_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int DEPTH      = DEFAULT_QUEUE_DEPTH;

  typedef struct packed {
    status_e            status;
    logic [NAME_W-1:0]  name;
    logic signed [15:0] prio;
    logic [4:0]         count;
  } job_result_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_MOSTLY} ready_mode_e;
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_e;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [1:0]            s_axis_tuser_i  = OP_NOP;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;

  // Bench copy of the queue contents, front job at index 0.
  logic [NAME_W-1:0]  held_name [DEPTH];
  logic signed [15:0] held_prio [DEPTH];
  int unsigned        held_count = 0;

  job_result_t  pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left     = 0;
  int unsigned  hold_off_left  = 0;
  int unsigned  mode_left      = 0;
  ready_mode_e  ready_mode     = RDY_ALWAYS;
  logic [15:0]  stall_pattern  = 16'hffff;
  logic [NAME_W-1:0] name_pool [8];

  sorted_priority_job_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Applies one operation to the bench copy and returns the word it causes.
  function automatic job_result_t apply_job_op(op_e op, logic [NAME_W-1:0] nm,
                                               logic signed [15:0] pr);
    job_result_t res;
    int unsigned slot;
    res = '{status: ST_OK, name: '0, prio: '0, count: '0};
    case (op)
      OP_ADD: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // A job at or below the tail priority goes behind everything.
          slot = held_count;
          if (held_count > 0 && pr > held_prio[held_count-1]) begin
            for (int i = held_count - 1; i >= 0; i--) begin
              if (held_prio[i] <= pr) slot = i;
            end
          end
          for (int i = held_count; i > slot; i--) begin
            held_name[i] = held_name[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_name[slot] = nm;
          held_prio[slot] = pr;
          held_count++;
        end
      end
      OP_REMOVE: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.name = held_name[0];
          res.prio = held_prio[0];
          for (int i = 0; i + 1 < held_count; i++) begin
            held_name[i] = held_name[i+1];
            held_prio[i] = held_prio[i+1];
          end
          held_count--;
        end
      end
      OP_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_name[i] == nm) begin
            res.status = ST_OK;
            res.name   = held_name[i];
            res.prio   = held_prio[i];
          end
        end
      end
      default: ;
    endcase
    res.count = held_count[4:0];
    return res;
  endfunction

  // Offers one word, with a random gap whenever a burst runs out. The valid
  // stays high after acceptance so that a following word goes out back to back.
  task automatic send_job(op_e op, logic [NAME_W-1:0] nm, logic signed [15:0] pr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pr, nm};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_job_op(op, nm, pr));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [NAME_W-1:0] random_name();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [15:0] random_prio();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 16'(signed'($urandom_range(0, 4)) - 2);
    if (pick < 6) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh8001;
        2: return 16'sh7ffe;
        default: return 16'sh7fff;
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic test_empty_queue();
    send_job(OP_REMOVE, random_name(), random_prio());
    send_job(OP_SEARCH, random_name(), random_prio());
    send_job(OP_NOP, random_name(), random_prio());
    drain_results();
  endtask

  // Ties, tail placement, extreme names and priorities, duplicate names.
  task automatic test_ordering();
    logic [NAME_W-1:0] first_name;
    logic [NAME_W-1:0] tail_name;
    first_name = random_name();
    tail_name  = random_name();
    send_job(OP_ADD, first_name, 16'sd5);
    send_job(OP_ADD, tail_name, 16'sd5);
    send_job(OP_ADD, '1, 16'sh7fff);
    send_job(OP_ADD, '0, 16'sh8000);
    send_job(OP_ADD, random_name(), 16'sd5);
    send_job(OP_ADD, random_name(), 16'sd0);
    send_job(OP_SEARCH, tail_name, random_prio());
    send_job(OP_ADD, first_name, 16'sd100);
    send_job(OP_SEARCH, first_name, random_prio());
    send_job(OP_SEARCH, '0, random_prio());
    send_job(OP_NOP, '1, 16'sh7fff);
    repeat (8) send_job(OP_REMOVE, random_name(), random_prio());
    drain_results();
  endtask

  // The output side holds off for a long time while words keep coming, so the
  // result register fills and the input side has to stall.
  task automatic test_backpressure();
    hold_off_left = 300;
    repeat (40) begin
      send_job(($urandom_range(0, 2) == 0) ? OP_REMOVE : OP_ADD,
               name_pool[$urandom_range(0, 7)], random_prio());
    end
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    traffic_mix_e mix;
    int unsigned  mix_left;
    int unsigned  roll;
    op_e          op;
    logic [NAME_W-1:0] nm;
    mix      = MIX_FILL;
    mix_left = 0;
    repeat (n_items) begin
      if (mix_left == 0) begin
        mix      = traffic_mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(20, 60);
      end
      mix_left--;
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  op = (roll < 80) ? OP_ADD : (roll < 90) ? OP_SEARCH :
                        (roll < 95) ? OP_REMOVE : OP_NOP;
        MIX_DRAIN: op = (roll < 75) ? OP_REMOVE : (roll < 90) ? OP_SEARCH :
                        (roll < 98) ? OP_ADD : OP_NOP;
        default:   op = (roll < 40) ? OP_ADD : (roll < 75) ? OP_REMOVE :
                        (roll < 97) ? OP_SEARCH : OP_NOP;
      endcase
      roll = $urandom_range(0, 9);
      nm   = random_name();
      if (op == OP_SEARCH && roll < 6 && held_count > 0)
        nm = held_name[$urandom_range(0, held_count - 1)];
      else if (roll < 8)
        nm = name_pool[$urandom_range(0, 7)];
      send_job(op, nm, random_prio());
    end
    drain_results();
  endtask

  // Output side ready: a long hold-off when asked for, otherwise one of a few
  // stall styles, picked at random and changed at random intervals.
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      hold_off_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode    = ready_mode_e'($urandom_range(0, 3));
        mode_left     = $urandom_range(20, 200);
        stall_pattern = 16'($urandom);
      end else begin
        mode_left--;
      end
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      case (ready_mode)
        RDY_ALWAYS:  m_axis_tready_i <= 1'b1;
        RDY_COIN:    m_axis_tready_i <= 1'($urandom_range(0, 1));
        RDY_PATTERN: m_axis_tready_i <= stall_pattern[0];
        default:     m_axis_tready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    job_result_t seen;
    job_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen.status = status_e'(m_axis_tuser_o);
      seen.name   = m_axis_tdata_o[63:0];
      seen.prio   = m_axis_tdata_o[79:64];
      seen.count  = m_axis_tdata_o[84:80];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %s name %h prio %0d count %0d",
                   seen.status.name(), seen.name, seen.prio, seen.count);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want || m_axis_tdata_o[87:85] !== 3'b000) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %s name %h prio %0d count %0d, got %s %h %0d %0d pad %b",
                     want.status.name(), want.name, want.prio, want.count,
                     seen.status.name(), seen.name, seen.prio, seen.count,
                     m_axis_tdata_o[87:85]);
        end
      end
    end
  end

  initial begin
    foreach (name_pool[i]) name_pool[i] = random_name();
    name_pool[0] = '0;
    name_pool[1] = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_ordering();
    test_backpressure();
    test_random_traffic(990);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 400_000);
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/spjq_pkg.sv
rtl/spjq_cell.sv
rtl/sorted_priority_job_queue.sv
test/sorted_priority_job_queue_tb.sv
